@@ rtl/svg_pkg.sv @@
package svg_pkg;

   localparam int unsigned AXIS_W      = 9;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned RADIUS_W    = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned RECIP_W     = 36;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam int unsigned PROD_W      = AXIS_W + RECIP_W;
   localparam int unsigned FRAC_W      = PROD_W - (RECIP_SHIFT - 17);
   localparam int unsigned POS_W       = 17;
   localparam int unsigned NORM_W      = 16;
   localparam int unsigned TEX_W       = 17;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 136;

   localparam logic [CSR_INDEX_W-1:0] CSR_AROUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS = 2'd2;

   localparam logic [AXIS_W-1:0]   AROUND_RESET = 9'd32;
   localparam logic [AXIS_W-1:0]   POLE_RESET   = 9'd16;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

   localparam logic [5:0] CORNER_DA   = 6'b010110;
   localparam logic [5:0] CORNER_DB   = 6'b110100;
   localparam logic [2:0] LAST_CORNER = 3'd5;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

   typedef struct packed {
      logic [INDEX_W-1:0] around;
      logic [INDEX_W-1:0] pole;
      logic               bad;
   } quad_type;

   // quarter-wave sine entry in Q14, elaboration only
   function automatic logic [14:0] quarter_sine(int unsigned bits, int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          v;
      x    = (PI_HALF_Q30 * longint'(k)) >> (bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[n-1];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum + 32768) >>> 16;
      if (v > 16384) begin
         v = 16384;
      end
      return 15'(v);
   endfunction

endpackage

@@ rtl/svg_recip.sv @@
module svg_recip
   import svg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [AXIS_W-1:0]   around_div,
   input  logic [AXIS_W-1:0]   pole_div,
   output logic [RECIP_W-1:0]  around_recip,
   output logic [RECIP_W-1:0]  pole_recip,
   output logic                busy
);

   logic               start_ff, start_in;
   logic               run_ff, run_in;
   logic [5:0]         count_ff, count_in;
   logic [RECIP_W-1:0] num_ff [2];
   logic [RECIP_W-1:0] num_in [2];
   logic [AXIS_W-1:0]  rem_ff [2];
   logic [AXIS_W-1:0]  rem_in [2];
   logic [AXIS_W-1:0]  div [2];
   logic [AXIS_W:0]    shifted;

   assign div[0] = around_div;
   assign div[1] = pole_div;

   // ceil(2^35 / d) by restoring division, one quotient bit per cycle
   always_comb begin
      start_in = start;
      run_in   = run_ff;
      count_in = count_ff;
      shifted  = '0;
      for (int i = 0; i < 2; i++) begin
         num_in[i] = num_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (start_ff) begin
         run_in   = 1'b1;
         count_in = '0;
         for (int i = 0; i < 2; i++) begin
            num_in[i] = (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(div[i]) - RECIP_W'(1);
            rem_in[i] = '0;
         end
      end else if (run_ff) begin
         for (int i = 0; i < 2; i++) begin
            shifted = {rem_ff[i], num_ff[i][RECIP_W-1]};
            if (shifted >= {1'b0, div[i]}) begin
               rem_in[i] = AXIS_W'(shifted - {1'b0, div[i]});
               num_in[i] = {num_ff[i][RECIP_W-2:0], 1'b1};
            end else begin
               rem_in[i] = shifted[AXIS_W-1:0];
               num_in[i] = {num_ff[i][RECIP_W-2:0], 1'b0};
            end
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'(RECIP_W - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         start_ff <= start_in;
         run_ff   <= run_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign around_recip = num_ff[0];
   assign pole_recip   = num_ff[1];
   assign busy         = start_ff | run_ff;

endmodule

@@ rtl/svg_front.sv @@
module svg_front
   import svg_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS = 256
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [INDEX_W-1:0]  around_index,
   input  logic [INDEX_W-1:0]  pole_index,
   input  logic [AXIS_W-1:0]   around_segments,
   input  logic [AXIS_W-1:0]   pole_segments,
   input  logic                hold,
   output logic                head_valid,
   output quad_type            head,
   input  logic                pop
);

   localparam int unsigned CMP_W = 14;

   quad_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       do_pop;
   logic       bad;

   always_comb begin
      bad = (around_segments == '0) || (pole_segments == '0) ||
            (CMP_W'(around_segments) > CMP_W'(MAX_SEGMENTS)) ||
            (CMP_W'(pole_segments) > CMP_W'(MAX_SEGMENTS)) ||
            ({1'b0, around_index} >= around_segments) ||
            ({1'b0, pole_index} >= pole_segments);
   end

   assign in_ready   = (fill_ff != 2'd2) && !hold;
   assign push       = in_valid && in_ready;
   assign head_valid = (fill_ff != 2'd0);
   assign do_pop     = pop && head_valid;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{around: around_index, pole: pole_index, bad: bad};
      end
   end

endmodule

@@ rtl/svg_back.sv @@
module svg_back
   import svg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_BITS = 10
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  quad_type                  head,
   output logic                      pop,
   input  logic [RECIP_W-1:0]        around_recip,
   input  logic [RECIP_W-1:0]        pole_recip,
   input  logic [RADIUS_W-1:0]       sphere_radius,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [POS_W-1:0]   pos_x,
   output logic signed [POS_W-1:0]   pos_y,
   output logic signed [POS_W-1:0]   pos_z,
   output logic signed [NORM_W-1:0]  norm_x,
   output logic signed [NORM_W-1:0]  norm_y,
   output logic signed [NORM_W-1:0]  norm_z,
   output logic [TEX_W-1:0]          tex_u,
   output logic [TEX_W-1:0]          tex_v,
   output logic                      last_corner,
   output logic                      bad_index
);

   localparam int unsigned B   = SINE_TABLE_BITS;
   localparam int unsigned QS  = 1 << (B - 2);
   localparam int unsigned QI_W = B - 1;

   logic [14:0] qtab [QS+1];

   for (genvar g = 0; g <= QS; g++) begin : g_qtab
      localparam logic [14:0] QV = quarter_sine(B, g);
      assign qtab[g] = QV;
   end

   logic en;
   logic [2:0] corner_ff, corner_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic l1_ff, l2_ff, l3_ff, l4_ff, l5_ff, l6_ff;
   logic b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff;

   logic [AXIS_W-1:0] a1_ff, b1i_ff;
   logic [PROD_W-1:0] pa2_ff, pb2_ff;
   logic [B-1:0]      ph3a_ff, ph3t_ff;
   logic [TEX_W-1:0]  u3_ff, v3t_ff, u4_ff, v4t_ff, u5_ff, v5t_ff;
   logic signed [NORM_W-1:0] trig4_ff [4];
   logic signed [NORM_W-1:0] nx5_ff, ny5_ff, nz5_ff;

   logic [FRAC_W-1:0] fa, fb;
   logic [FRAC_W+B-17:0] pa_full;
   logic [FRAC_W+B-18:0] pt_full;
   logic [FRAC_W:0] fa1, fb1;
   logic [B-1:0] pa, pt;
   logic [B-1:0] ph [4];
   logic [QI_W-1:0] qidx;
   logic signed [NORM_W-1:0] trig [4];
   logic signed [2*NORM_W-1:0] prod_x, prod_z;
   logic signed [RADIUS_W+NORM_W:0] rx, ry, rz;

   assign en  = !out_valid || out_ready;
   assign pop = en && head_valid && (corner_ff == LAST_CORNER);

   always_comb begin
      corner_in = corner_ff;
      if (en && head_valid) begin
         corner_in = (corner_ff == LAST_CORNER) ? 3'd0 : corner_ff + 3'd1;
      end
   end

   // phases and texture coordinates from the scaled quotients
   always_comb begin
      fa      = FRAC_W'(pa2_ff >> (RECIP_SHIFT - 17));
      fb      = FRAC_W'(pb2_ff >> (RECIP_SHIFT - 17));
      pa_full = fa[FRAC_W-1:16-B] + 1'b1;
      pt_full = fb[FRAC_W-1:17-B] + 1'b1;
      pa      = pa_full[B:1];
      pt      = pt_full[B:1] - B'(QS);
      fa1     = {1'b0, fa} + 1'b1;
      fb1     = {1'b0, fb} + 1'b1;
   end

   always_comb begin
      ph[0] = ph3a_ff;
      ph[1] = ph3a_ff + B'(QS);
      ph[2] = ph3t_ff;
      ph[3] = ph3t_ff + B'(QS);
      for (int i = 0; i < 4; i++) begin
         if (ph[i][B-2]) begin
            qidx = QI_W'(QS) - QI_W'(ph[i][B-3:0]);
         end else begin
            qidx = QI_W'(ph[i][B-3:0]);
         end
         if (ph[i][B-1]) begin
            trig[i] = -NORM_W'(qtab[qidx]);
         end else begin
            trig[i] = NORM_W'(qtab[qidx]);
         end
      end
   end

   always_comb begin
      prod_x = trig4_ff[0] * trig4_ff[3];
      prod_z = trig4_ff[1] * trig4_ff[3];
      rx = $signed({1'b0, sphere_radius}) * nx5_ff;
      ry = $signed({1'b0, sphere_radius}) * ny5_ff;
      rz = $signed({1'b0, sphere_radius}) * nz5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         corner_ff <= corner_in;
         if (en) begin
            v1_ff <= head_valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
            v6_ff <= v5_ff;
         end
      end
      if (en) begin
         a1_ff  <= {1'b0, head.around} + AXIS_W'(CORNER_DA[corner_ff]);
         b1i_ff <= {1'b0, head.pole} + AXIS_W'(CORNER_DB[corner_ff]);
         l1_ff  <= (corner_ff == LAST_CORNER);
         b1_ff  <= head.bad;

         pa2_ff <= PROD_W'(a1_ff) * PROD_W'(around_recip);
         pb2_ff <= PROD_W'(b1i_ff) * PROD_W'(pole_recip);
         l2_ff  <= l1_ff;
         b2_ff  <= b1_ff;

         ph3a_ff <= pa;
         ph3t_ff <= pt;
         u3_ff   <= fa1[TEX_W:1];
         v3t_ff  <= TEX_W'(18'd65536 - 18'(fb1[TEX_W:1]));
         l3_ff   <= l2_ff;
         b3_ff   <= b2_ff;

         trig4_ff <= trig;
         u4_ff    <= u3_ff;
         v4t_ff   <= v3t_ff;
         l4_ff    <= l3_ff;
         b4_ff    <= b3_ff;

         nx5_ff <= NORM_W'((prod_x + 32'sd8192) >>> 14);
         nz5_ff <= NORM_W'((prod_z + 32'sd8192) >>> 14);
         ny5_ff <= trig4_ff[2];
         u5_ff  <= u4_ff;
         v5t_ff <= v4t_ff;
         l5_ff  <= l4_ff;
         b5_ff  <= b4_ff;

         if (b5_ff) begin
            pos_x  <= '0;
            pos_y  <= '0;
            pos_z  <= '0;
            norm_x <= '0;
            norm_y <= '0;
            norm_z <= '0;
            tex_u  <= '0;
            tex_v  <= '0;
         end else begin
            pos_x  <= POS_W'((rx + 33'sd8192) >>> 14);
            pos_y  <= POS_W'((ry + 33'sd8192) >>> 14);
            pos_z  <= POS_W'((rz + 33'sd8192) >>> 14);
            norm_x <= nx5_ff;
            norm_y <= ny5_ff;
            norm_z <= nz5_ff;
            tex_u  <= u5_ff;
            tex_v  <= v5t_ff;
         end
         l6_ff <= l5_ff;
         b6_ff <= b5_ff;
      end
   end

   assign out_valid   = v6_ff;
   assign last_corner = l6_ff;
   assign bad_index   = b6_ff;

endmodule

@@ rtl/uv_sphere_vertex_generator_top.sv @@
// UV sphere vertex generator. Each request transaction carries one quad (column in
// req_tdata[7:0], row in req_tdata[15:8]) and yields six vertex transactions, one per
// cycle unless rsp_tready stalls them, and quads stream back to back, limited by the
// single result channel. A six-stage vertex pipeline sits behind a two-entry request
// queue. After reset and after every csr write the block computes reciprocals of the
// segment counts by a bit-serial divider, during which req_tready stays low.
// Out-of-range requests still give six vertices, flagged in tuser with zero geometry.
module uv_sphere_vertex_generator_top
   import svg_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS    = 256,
   parameter int unsigned SINE_TABLE_BITS = 10
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // around_index, pole_index
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y,
                                                // norm_z, tex_u, tex_v, zero pad
   output logic                    rsp_tlast,
   output logic                    rsp_tuser,   // bad_index
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   logic [AXIS_W-1:0]   around_ff, pole_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic                csr_write;
   logic [RECIP_W-1:0]  around_recip, pole_recip;
   logic                recip_busy;
   logic                head_valid, pop;
   quad_type            head;
   logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
   logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
   logic [TEX_W-1:0]    tex_u, tex_v;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         around_ff <= AROUND_RESET;
         pole_ff   <= POLE_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AROUND: around_ff <= csr_data[AXIS_W-1:0];
            CSR_POLE:   pole_ff   <= csr_data[AXIS_W-1:0];
            CSR_RADIUS: radius_ff <= csr_data;
            default: ;
         endcase
      end
   end

   svg_recip u_recip (
      .clock        (clock),
      .reset        (reset),
      .start        (csr_write),
      .around_div   (around_ff),
      .pole_div     (pole_ff),
      .around_recip (around_recip),
      .pole_recip   (pole_recip),
      .busy         (recip_busy)
   );

   svg_front #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .around_index    (req_tdata[7:0]),
      .pole_index      (req_tdata[15:8]),
      .around_segments (around_ff),
      .pole_segments   (pole_ff),
      .hold            (recip_busy),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop)
   );

   svg_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .around_recip  (around_recip),
      .pole_recip    (pole_recip),
      .sphere_radius (radius_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .pos_x         (pos_x),
      .pos_y         (pos_y),
      .pos_z         (pos_z),
      .norm_x        (norm_x),
      .norm_y        (norm_y),
      .norm_z        (norm_z),
      .tex_u         (tex_u),
      .tex_v         (tex_v),
      .last_corner   (rsp_tlast),
      .bad_index     (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, tex_v, tex_u, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};

`ifndef SYNTHESIS
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      recip_busy |-> !req_tready)
      else $error("request taken during reciprocal update");

   a_write_starts_recip: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> recip_busy)
      else $error("csr write did not restart reciprocal unit");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected quad carries geometry");
`endif

endmodule

@@ dv/uv_sphere_vertex_generator_top_tb.sv @@
module uv_sphere_vertex_generator_top_tb;
   import svg_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned TABLE_BITS = 10;
   localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);
   localparam int unsigned TURN_MASK = (1 << TABLE_BITS) - 1;
   localparam int unsigned SEG_LIMIT = 256;
   localparam int unsigned DRAIN_CYCLES = 24;

   typedef struct {
      logic [7:0] around;
      logic [7:0] pole;
   } quad_item;

   typedef struct {
      logic [POS_W-1:0]  px, py, pz;
      logic [NORM_W-1:0] nx, ny, nz;
      logic [TEX_W-1:0]  u, v;
      logic              last;
      logic              bad;
   } vertex_item;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   quad_item   pending_quads[$];
   vertex_item expected_vertices[$];
   int unsigned around_cfg, pole_cfg, radius_cfg;
   int unsigned send_idle_pct, recv_stall_pct;
   int unsigned mismatches, quads_sent, vertices_seen, rejected_seen;
   logic        req_fire;
   logic        hold_go;
   logic        hold_done;
   int unsigned hold_left;

   uv_sphere_vertex_generator_top dut (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint quarter_sine(int unsigned k);
      longint unsigned x, x2, term;
      longint sum, v;
      x = (64'd1686629713 * k) >> (TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x2) >> 30;
         term = term / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 32768) >>> 16;
      if (v > 16384) v = 16384;
      return v;
   endfunction

   function automatic longint turn_sine(int unsigned p);
      int unsigned q, r;
      p = p & TURN_MASK;
      q = p >> (TABLE_BITS - 2);
      r = p & (QUARTER - 1);
      case (q)
         0: return quarter_sine(r);
         1: return quarter_sine(QUARTER - r);
         2: return -quarter_sine(r);
         default: return -quarter_sine(QUARTER - r);
      endcase
   endfunction

   function automatic longint q14_round(longint p);
      return (p + 8192) >>> 14;
   endfunction

   task automatic predict_quad(logic [7:0] ai, logic [7:0] bi);
      vertex_item vtx;
      logic       bad;
      longint unsigned a, b, pa, pt;
      longint     sa, ca, st, ct, nx, ny, nz;
      bad = around_cfg == 0 || around_cfg > SEG_LIMIT || pole_cfg == 0 ||
            pole_cfg > SEG_LIMIT || ai >= around_cfg || bi >= pole_cfg;
      for (int k = 0; k < 6; k++) begin
         vtx = '{default: '0};
         vtx.last = (k == LAST_CORNER);
         vtx.bad = bad;
         if (!bad) begin
            a = ai + CORNER_DA[k];
            b = bi + CORNER_DB[k];
            pa = (((a << (TABLE_BITS + 1)) + around_cfg) / (2 * around_cfg)) & TURN_MASK;
            pt = ((((b << TABLE_BITS) + pole_cfg) / (2 * pole_cfg)) +
                  (1 << TABLE_BITS) - QUARTER) & TURN_MASK;
            sa = turn_sine(pa);
            ca = turn_sine(pa + QUARTER);
            st = turn_sine(pt);
            ct = turn_sine(pt + QUARTER);
            nx = q14_round(sa * ct);
            ny = st;
            nz = q14_round(ca * ct);
            vtx.px = POS_W'(q14_round(longint'(radius_cfg) * nx));
            vtx.py = POS_W'(q14_round(longint'(radius_cfg) * ny));
            vtx.pz = POS_W'(q14_round(longint'(radius_cfg) * nz));
            vtx.nx = NORM_W'(nx);
            vtx.ny = NORM_W'(ny);
            vtx.nz = NORM_W'(nz);
            vtx.u = TEX_W'(((a << 17) + around_cfg) / (2 * around_cfg));
            vtx.v = TEX_W'(65536 - ((b << 17) + pole_cfg) / (2 * pole_cfg));
         end
         expected_vertices.insert(expected_vertices.size(), vtx);
      end
   endtask

   task automatic report(string what, longint got, longint want);
      mismatches++;
      $display("vertex %0d: %s got 0x%0h want 0x%0h", vertices_seen, what, got, want);
   endtask

   task automatic check_field(string what, longint got, longint want);
      if (got != want) report(what, got, want);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fire) void'(pending_quads.pop_front());
         if (req_tvalid && !req_fire) begin
            req_tvalid <= 1'b1;
         end else if (pending_quads.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= {pending_quads[0].pole, pending_quads[0].around};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_go && !hold_done) begin
         if (hold_left == 0 && !hold_done) hold_left <= 400;
         if (hold_left == 1) hold_done <= 1'b1;
         if (hold_left > 0) hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      vertex_item want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            quads_sent++;
            predict_quad(req_tdata[7:0], req_tdata[15:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            vertices_seen++;
            if (rsp_tuser) rejected_seen++;
            if (expected_vertices.size() == 0) begin
               report("unexpected transaction", 1, 0);
            end else begin
               want = expected_vertices.pop_front();
               check_field("pos_x", rsp_tdata[16:0], want.px);
               check_field("pos_y", rsp_tdata[33:17], want.py);
               check_field("pos_z", rsp_tdata[50:34], want.pz);
               check_field("norm_x", rsp_tdata[66:51], want.nx);
               check_field("norm_y", rsp_tdata[82:67], want.ny);
               check_field("norm_z", rsp_tdata[98:83], want.nz);
               check_field("tex_u", rsp_tdata[115:99], want.u);
               check_field("tex_v", rsp_tdata[132:116], want.v);
               check_field("pad", rsp_tdata[135:133], 0);
               check_field("last_corner", rsp_tlast, want.last);
               check_field("bad_index", rsp_tuser, want.bad);
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_AROUND: around_cfg = value[AXIS_W-1:0];
         CSR_POLE: pole_cfg = value[AXIS_W-1:0];
         CSR_RADIUS: radius_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_quads.size() != 0 || req_tvalid || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_quad(int unsigned a, int unsigned b);
      pending_quads.insert(pending_quads.size(), '{around: a[7:0], pole: b[7:0]});
   endtask

   task automatic random_quads(int unsigned count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85 && around_cfg >= 1 && around_cfg <= SEG_LIMIT &&
             pole_cfg >= 1 && pole_cfg <= SEG_LIMIT)
            push_quad($urandom_range(around_cfg - 1), $urandom_range(pole_cfg - 1));
         else
            push_quad($urandom_range(255), $urandom_range(255));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_fire = 1'b0;
      hold_go = 1'b0;
      around_cfg = 32;
      pole_cfg = 16;
      radius_cfg = 256;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      quads_sent = 0;
      vertices_seen = 0;
      rejected_seen = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset configuration: corners, seam, poles, out of range
      push_quad(0, 0);
      push_quad(31, 15);
      push_quad(31, 0);
      push_quad(0, 15);
      push_quad(16, 8);
      push_quad(32, 0);
      push_quad(0, 16);
      push_quad(255, 255);
      wait_idle();

      csr_write(CSR_AROUND, 16'd1);
      csr_write(CSR_POLE, 16'd1);
      csr_write(CSR_RADIUS, 16'hFFFF);
      push_quad(0, 0);
      push_quad(1, 0);
      push_quad(0, 1);
      wait_idle();

      csr_write(CSR_AROUND, 16'hFF00 | 16'd256);
      csr_write(CSR_POLE, 16'd256);
      csr_write(CSR_RADIUS, 16'd0);
      csr_write(CSR_UNUSED, 16'hFFFF);
      push_quad(255, 255);
      push_quad(0, 0);
      push_quad(128, 128);
      wait_idle();

      csr_write(CSR_RADIUS, 16'h8001);
      push_quad(255, 0);
      push_quad(64, 192);
      wait_idle();
      csr_write(CSR_AROUND, 16'd0);
      push_quad(0, 0);
      wait_idle();
      csr_write(CSR_AROUND, 16'd300);
      push_quad(5, 5);
      wait_idle();
      csr_write(CSR_AROUND, 16'd7);
      csr_write(CSR_POLE, 16'd0);
      push_quad(0, 0);
      wait_idle();
      csr_write(CSR_POLE, 16'd511);
      push_quad(6, 3);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 46; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 46; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         csr_write(CSR_AROUND, 16'($urandom_range(SEG_LIMIT, 1)));
         csr_write(CSR_POLE, 16'($urandom_range(SEG_LIMIT, 1)));
         csr_write(CSR_RADIUS, 16'($urandom_range(16'hFFFF)));
         if (phase == 0) hold_go = 1'b1;
         random_quads(22);
         wait_idle();
         if (phase == 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            random_quads(6);
            wait_idle();
         end
      end

      $display("%0d quads sent, %0d vertices checked, %0d flagged out of range",
               quads_sent, vertices_seen, rejected_seen);
      $display("covered reset, minimum, maximum and invalid segment counts with idle mixes");
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
